// ===== rtl/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types and constants for the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package cce_pkg;

    localparam int PX_W    = 24;
    localparam int COEF_W  = 16;
    localparam int KROW_W  = 48;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int Q_DEPTH = 4;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);
    localparam int PROD_W  = 25;
    localparam int RSUM_W  = 27;
    localparam int SUM_W   = 30;

    typedef logic [PX_W-1:0] pixel_t;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        REG_KTOP   = 3'd0,
        REG_KMID   = 3'd1,
        REG_KBOT   = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } reg_idx_t;

    // One output's column slice: column c+1 (clamped) of the three rows,
    // plus column 0 for the first output of a row.
    typedef struct packed
    {
        pixel_t top_a;
        pixel_t mid_a;
        pixel_t bot_a;
        pixel_t top_b;
        pixel_t mid_b;
        pixel_t bot_b;
        logic   first_col;
        logic   frame_end;
    } job_t;

endpackage

// ===== rtl/conv3x3_rgb_edge_clamp_top.sv =====
// ----------------------------------------------------------------------------
// conv3x3_rgb_edge_clamp_top
// 3x3 RGB convolution with edge-clamped borders and Q4.12 kernel.
//
//  channel | direction | signals                      | payload
//  s_*     | in        | s_tvalid/s_tready            | tdata rgb, tuser opcode
//  m_*     | out       | m_tvalid/m_tready            | tdata rgb, tlast frame_end
//  apb     | in        | psel/penable/pwrite/pready   | kernel rows, width, height
//
//  One item per clock while the job queue has room; an output leaves through
//  line store read, window, products, row sums and round registers.
//  A 4-entry job queue sits between the front end and the filter datapath,
//  so inputs keep flowing while an output waits on m_tready, until the queue fills.
//  Reset clears positions and queue; line stores are not cleared.
// ----------------------------------------------------------------------------
module conv3x3_rgb_edge_clamp_top
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [KROW_W-1:0] ktop_reg, kmid_reg, kbot_reg;
    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic              wr;
    reg_idx_t          idx;
    logic              geom_clear;
    logic [QCNT_W-1:0] q_count;
    logic              push, pop, q_empty;
    job_t              push_job, head_job;

    assign pready     = 1'b1;
    assign idx        = reg_idx_t'(paddr[5:3]);
    assign wr         = psel & penable & pwrite & pready;
    assign geom_clear = wr && (idx == REG_WIDTH || idx == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ktop_reg <= '0;
            kmid_reg <= KROW_W'(4096);
            kbot_reg <= '0;
            fw_reg   <= FW_W'(640);
            fh_reg   <= FH_W'(480);
        end
        else if (wr)
        begin
            unique case (idx)
                REG_KTOP:   ktop_reg <= pwdata[KROW_W-1:0];
                REG_KMID:   kmid_reg <= pwdata[KROW_W-1:0];
                REG_KBOT:   kbot_reg <= pwdata[KROW_W-1:0];
                REG_WIDTH:  fw_reg   <= pwdata[FW_W-1:0];
                REG_HEIGHT: fh_reg   <= pwdata[FH_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KTOP:   prdata = 64'(ktop_reg);
            REG_KMID:   prdata = 64'(kmid_reg);
            REG_KBOT:   prdata = 64'(kbot_reg);
            REG_WIDTH:  prdata = 64'(fw_reg);
            REG_HEIGHT: prdata = 64'(fh_reg);
            default:    prdata = '0;
        endcase
    end

    cce_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .frame_width  (fw_reg),
        .frame_height (fh_reg),
        .geom_clear   (geom_clear),
        .q_count      (q_count),
        .push         (push),
        .push_job     (push_job)
    );

    cce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .count    (q_count)
    );

    cce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_job   (head_job),
        .pop        (pop),
        .kernel_top (ktop_reg),
        .kernel_mid (kmid_reg),
        .kernel_bot (kbot_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/cce_ram.sv =====
// ----------------------------------------------------------------------------
// cce_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cce_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/cce_queue.sv =====
// ----------------------------------------------------------------------------
// cce_queue
// Small job FIFO between the front end and the filter datapath.
// ----------------------------------------------------------------------------
module cce_queue
    import cce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  job_t              push_job,
    input  logic              pop,
    output job_t              head_job,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    job_t               slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    assign head_job = slot_reg[rptr_reg];
    assign empty    = (cnt_reg == '0);
    assign count    = cnt_reg;

endmodule

// ===== rtl/cce_front.sv =====
// ----------------------------------------------------------------------------
// cce_front
// Input side: position tracking, line stores, emit decision, column fetch.
// ----------------------------------------------------------------------------
module cce_front
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic              s_tuser,
    input  logic [FW_W-1:0]   frame_width,
    input  logic [FH_W-1:0]   frame_height,
    input  logic              geom_clear,
    input  logic [QCNT_W-1:0] q_count,
    output logic              push,
    output job_t              push_job
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int LAG_W = $clog2(MAX_WIDTH + 3);

    logic [WID_W-1:0] w_eff;
    logic [FH_W-1:0]  h_eff;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [FH_W-1:0]  in_row_reg, in_row_next;
    logic [1:0]       in_m3_reg, in_m3_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [FH_W-1:0]  out_row_reg, out_row_next;
    logic [1:0]       out_m3_reg, out_m3_next;
    logic [LAG_W-1:0] lag_reg, lag_next;

    logic             accept, is_px, full, wr_en, emit, last_px;
    logic             in_wrap, out_wrap;
    logic [COL_W-1:0] rd_col;
    logic [1:0]       top_sel, bot_sel;
    pixel_t           px_in;
    logic [2:0]       fwd_a, fwd_b;

    logic             s1_valid_reg;
    logic             s1_first_reg, s1_end_reg;
    logic [1:0]       s1_top_reg, s1_mid_reg, s1_bot_reg;
    logic [2:0]       s1_fwd_a_reg, s1_fwd_b_reg;
    pixel_t           s1_px_reg;

    pixel_t           rda [3];
    pixel_t           rdb [3];
    pixel_t           col_a [3];
    pixel_t           col_b [3];

    always_comb
    begin
        if (frame_width == '0)
            w_eff = WID_W'(1);
        else if (32'(frame_width) > MAX_WIDTH)
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = WID_W'(frame_width);
        h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
    end

    assign px_in    = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign s_tready = (32'(q_count) + 32'(s1_valid_reg)) < Q_DEPTH;
    assign accept   = s_tvalid & s_tready;
    assign is_px    = (opcode_t'(s_tuser) == OP_PIXEL);
    assign full     = (in_row_reg == h_eff);
    assign wr_en    = accept & is_px & ~full;
    assign last_px  = (out_row_reg == h_eff - 1'b1) && (WID_W'(out_col_reg) == w_eff - 1'b1);
    // Output waits until its lower-right neighbor is in; drains run once the frame is in.
    assign emit     = accept & ((wr_en & (lag_reg >= LAG_W'(w_eff) + 1'b1)) | (~is_px & full));
    assign in_wrap  = (WID_W'(in_col_reg) + 1'b1 == w_eff);
    assign out_wrap = (WID_W'(out_col_reg) + 1'b1 == w_eff);

    always_comb
    begin
        rd_col  = (WID_W'(out_col_reg) == w_eff - 1'b1) ? out_col_reg : out_col_reg + 1'b1;
        top_sel = (out_row_reg == '0) ? out_m3_reg
                : ((out_m3_reg == 2'd0) ? 2'd2 : out_m3_reg - 1'b1);
        bot_sel = (out_row_reg == h_eff - 1'b1) ? out_m3_reg
                : ((out_m3_reg == 2'd2) ? 2'd0 : out_m3_reg + 1'b1);
        // only the bottom row can be written in the cycle it is read; a write to
        // the top row's store must not replace the old pixel
        for (int k = 0; k < 3; k++)
        begin
            fwd_a[k] = wr_en && (in_m3_reg == 2'(k)) && (bot_sel == 2'(k))
                    && (in_col_reg == rd_col);
            fwd_b[k] = wr_en && (in_m3_reg == 2'(k)) && (bot_sel == 2'(k))
                    && (in_col_reg == '0);
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_m3_next   = in_m3_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_m3_next  = out_m3_reg;
        lag_next     = lag_reg + LAG_W'(wr_en) - LAG_W'(emit);
        if (wr_en)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
                in_m3_next  = (in_m3_reg == 2'd2) ? 2'd0 : in_m3_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
        if (emit)
        begin
            if (out_wrap)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
                out_m3_next  = (out_m3_reg == 2'd2) ? 2'd0 : out_m3_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
        if (geom_clear || (emit && last_px))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_m3_next   = '0;
            out_col_next = '0;
            out_row_next = '0;
            out_m3_next  = '0;
            lag_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_m3_reg    <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_m3_reg   <= '0;
            lag_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_m3_reg    <= in_m3_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_m3_reg   <= out_m3_next;
            lag_reg      <= lag_next;
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (out_col_reg == '0);
        s1_end_reg   <= last_px;
        s1_top_reg   <= top_sel;
        s1_mid_reg   <= out_m3_reg;
        s1_bot_reg   <= bot_sel;
        s1_fwd_a_reg <= fwd_a;
        s1_fwd_b_reg <= fwd_b;
        s1_px_reg    <= px_in;
    end

    // Three line stores, row r lives in store r mod 3.
    for (genvar k = 0; k < 3; k++)
    begin : g_line
        cce_ram #(
            .WIDTH (PX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk     (clk),
            .we      (wr_en && (in_m3_reg == 2'(k))),
            .waddr   (in_col_reg),
            .wdata   (px_in),
            .raddr_a (rd_col),
            .raddr_b (COL_W'(0)),
            .rdata_a (rda[k]),
            .rdata_b (rdb[k])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            col_a[k] = s1_fwd_a_reg[k] ? s1_px_reg : rda[k];
            col_b[k] = s1_fwd_b_reg[k] ? s1_px_reg : rdb[k];
        end
        push               = s1_valid_reg;
        push_job.top_a     = col_a[s1_top_reg];
        push_job.mid_a     = col_a[s1_mid_reg];
        push_job.bot_a     = col_a[s1_bot_reg];
        push_job.top_b     = col_b[s1_top_reg];
        push_job.mid_b     = col_b[s1_mid_reg];
        push_job.bot_b     = col_b[s1_bot_reg];
        push_job.first_col = s1_first_reg;
        push_job.frame_end = s1_end_reg;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (32'(q_count) < Q_DEPTH))
        else $error("job queue overflow");

    a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LAG_W'(lag_reg) <= LAG_W'(w_eff) + 1'b1)
        else $error("input lead beyond one row plus one");

    a_emit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (out_row_reg < h_eff) && (WID_W'(out_col_reg) < w_eff))
        else $error("output position outside frame");

endmodule

// ===== rtl/cce_back.sv =====
// ----------------------------------------------------------------------------
// cce_back
// Filter datapath: 3x3 window, products, adder tree, round and saturate.
// ----------------------------------------------------------------------------
module cce_back
    import cce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  job_t              head_job,
    output logic              pop,
    input  logic [KROW_W-1:0] kernel_top,
    input  logic [KROW_W-1:0] kernel_mid,
    input  logic [KROW_W-1:0] kernel_bot,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tlast
);

    logic adv;

    pixel_t                   win_reg [3][3];
    logic                     v1_reg, v2_reg, v3_reg, vo_reg;
    logic                     e1_reg, e2_reg, e3_reg, eo_reg;
    logic signed [PROD_W-1:0] prod_reg [3][9];
    logic signed [RSUM_W-1:0] rsum_reg [3][3];
    logic [7:0]               ch_reg [3];
    logic [KROW_W-1:0]        krow [3];
    pixel_t                   col_a [3];
    pixel_t                   col_b [3];

    logic signed [SUM_W-1:0]  tot [3];
    logic [7:0]               ch_next [3];

    assign adv = ~vo_reg | m_tready;
    assign pop = adv & ~q_empty;

    assign krow[0]  = kernel_top;
    assign krow[1]  = kernel_mid;
    assign krow[2]  = kernel_bot;
    assign col_a[0] = head_job.top_a;
    assign col_a[1] = head_job.mid_a;
    assign col_a[2] = head_job.bot_a;
    assign col_b[0] = head_job.top_b;
    assign col_b[1] = head_job.mid_b;
    assign col_b[2] = head_job.bot_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= ~q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // Window shifts left by one column per output; a new row reloads it.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (head_job.first_col)
                begin
                    win_reg[r][0] <= col_b[r];
                    win_reg[r][1] <= col_b[r];
                end
                else
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[r][2] <= col_a[r];
            end
        end
        if (adv)
        begin
            e1_reg <= head_job.frame_end;
            e2_reg <= e1_reg;
            e3_reg <= e2_reg;
            eo_reg <= e3_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int t = 0; t < 9; t++)
                begin
                    prod_reg[ch][t] <= PROD_W'($signed({1'b0, win_reg[t/3][t%3][23-8*ch -: 8]})
                                     * $signed(krow[t/3][16*(t%3) +: 16]));
                end
                for (int r = 0; r < 3; r++)
                begin
                    rsum_reg[ch][r] <= RSUM_W'(prod_reg[ch][3*r])
                                     + RSUM_W'(prod_reg[ch][3*r+1])
                                     + RSUM_W'(prod_reg[ch][3*r+2]);
                end
                ch_reg[ch] <= ch_next[ch];
            end
        end
    end

    // Round half up from Q.12, clamp to 0..255.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            tot[ch] = SUM_W'(rsum_reg[ch][0]) + SUM_W'(rsum_reg[ch][1])
                    + SUM_W'(rsum_reg[ch][2]) + SUM_W'(2048);
            if (tot[ch] < 0)
                ch_next[ch] = 8'd0;
            else if (tot[ch][SUM_W-1:12] > 255)
                ch_next[ch] = 8'd255;
            else
                ch_next[ch] = tot[ch][19:12];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {ch_reg[2], ch_reg[1], ch_reg[0]};
    assign m_tlast  = eo_reg;

endmodule

// ===== verif/tb_conv3x3_rgb_edge_clamp_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv3x3_rgb_edge_clamp_top
// Self-checking bench for the 3x3 RGB edge-clamped convolution. A short
// stimulus table, then random frames of random geometry and kernels, with
// random idling on both streams and a long output stall. Every output is
// compared field by field against an in-bench convolution predictor.
// ----------------------------------------------------------------------------
module tb_conv3x3_rgb_edge_clamp_top;
    import cce_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int STORE_SIZE = 2 * LINE_MAX + 4;
    localparam int CYCLE_CAP  = 600000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } rgb_res_t;

    typedef struct {
        opcode_t    op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         has_res;
        rgb_res_t   res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red_in[7:0], green_in[15:8], blue_in[23:16]
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    conv3x3_rgb_edge_clamp_top DUT (.*);

    // predictor state
    logic [47:0] kern_row [3];
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] pix_store [STORE_SIZE];
    int unsigned in_col, in_row, out_col, out_row;

    rgb_res_t    pending_q [$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          frames_done;
    int          cycles;
    bit          idle_on;
    int          hold_cycles;
    int          stall_left;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int unsigned eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic logic [7:0] round_clip(input longint acc);
        longint t;
        t = acc + 2048;
        if (t < 0) return 8'd0;
        t = t >>> 12;
        return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    function automatic rgb_res_t convolve(input int unsigned w, input int unsigned h);
        rgb_res_t    r;
        longint      sr, sg, sb, k;
        int unsigned rr, cc, idx;
        logic [23:0] px;
        sr = 0; sg = 0; sb = 0;
        idx = out_row * w + out_col;
        for (int a = 0; a < 3; a++)
        begin
            rr = out_row + a;
            rr = (rr == 0) ? 0 : rr - 1;
            if (rr > h - 1) rr = h - 1;
            for (int b = 0; b < 3; b++)
            begin
                cc = out_col + b;
                cc = (cc == 0) ? 0 : cc - 1;
                if (cc > w - 1) cc = w - 1;
                px = pix_store[(rr * w + cc) % STORE_SIZE];
                k  = longint'($signed(kern_row[a][16*b +: 16]));
                sr += longint'(px[7:0]) * k;
                sg += longint'(px[15:8]) * k;
                sb += longint'(px[23:16]) * k;
            end
        end
        r.red   = round_clip(sr);
        r.green = round_clip(sg);
        r.blue  = round_clip(sb);
        r.last  = (idx == w * h - 1);
        if (r.last)
        begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        else if (++out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        return r;
    endfunction

    // advance the predictor by one accepted item
    task automatic conv_predict(input opcode_t op, input logic [23:0] px,
                                output bit got, output rgb_res_t res);
        int unsigned w, h, total, rcvd, pend;
        w = eff_w();
        h = eff_h();
        total = w * h;
        rcvd = in_row * w + in_col;
        pend = out_row * w + out_col;
        got = 0;
        if (op == OP_PIXEL)
        begin
            if (rcvd < total)
            begin
                pix_store[rcvd % STORE_SIZE] = px;
                if (++in_col >= w)
                begin
                    in_col = 0;
                    in_row++;
                end
                rcvd++;
                if (pend < total && rcvd >= pend + w + 2)
                begin
                    res = convolve(w, h);
                    got = 1;
                end
            end
        end
        else if (rcvd >= total && pend < total)
        begin
            res = convolve(w, h);
            got = 1;
        end
        if (got) pending_q.push_back(res);
    endtask

    task automatic send_item(input opcode_t op, input logic [23:0] px,
                             output bit got, output rgb_res_t res);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = px;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        conv_predict(op, px, got, res);
    endtask

    task automatic push_item(input opcode_t op, input logic [23:0] px);
        bit       got;
        rgb_res_t res;
        send_item(op, px, got, res);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        // pipeline may still be busy with an ignored item
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_KTOP:   kern_row[0] = val[47:0];
            REG_KMID:   kern_row[1] = val[47:0];
            REG_KBOT:   kern_row[2] = val[47:0];
            REG_WIDTH:  width_reg = val[10:0];
            REG_HEIGHT: height_reg = val[15:0];
            default: ;
        endcase
        if (idx == REG_WIDTH || idx == REG_HEIGHT)
        begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h1000;
            4: return 16'hF000;
            default: return 16'($urandom_range(0, 16'h0C00) - 16'h0300);
        endcase
    endfunction

    task automatic rand_kernel();
        reg_write(REG_KTOP, {16'h0, rand_coef(), rand_coef(), rand_coef()});
        reg_write(REG_KMID, {16'h0, rand_coef(), rand_coef(), rand_coef()});
        reg_write(REG_KBOT, {16'h0, rand_coef(), rand_coef(), rand_coef()});
    endtask

    // one frame with early-drain and ignored-pixel noise, optionally cut short
    task automatic run_frame(input bit cut_short);
        int unsigned total, stop_at;
        total = eff_w() * eff_h();
        stop_at = cut_short ? $urandom_range(1, total) : total;
        for (int unsigned i = 0; i < stop_at; i++)
        begin
            if ($urandom_range(0, 11) == 0) push_item(OP_DRAIN, 24'($urandom));
            push_item(OP_PIXEL, 24'($urandom));
        end
        if (cut_short) return;
        if ($urandom_range(0, 3) == 0) push_item(OP_PIXEL, 24'($urandom));
        for (int unsigned i = 0; i <= eff_w(); i++) push_item(OP_DRAIN, 24'($urandom));
        if ($urandom_range(0, 3) == 0) push_item(OP_DRAIN, 24'($urandom));
        frames_done++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rgb_res_t e;
            results_seen++;
            if (pending_q.size() == 0)
                report($sformatf("unexpected output %h last=%b", m_tdata, m_tlast));
            else
            begin
                e = pending_q.pop_front();
                if (m_tdata[7:0] !== e.red)
                    report($sformatf("red %h, want %h", m_tdata[7:0], e.red));
                if (m_tdata[15:8] !== e.green)
                    report($sformatf("green %h, want %h", m_tdata[15:8], e.green));
                if (m_tdata[23:16] !== e.blue)
                    report($sformatf("blue %h, want %h", m_tdata[23:16], e.blue));
                if (m_tlast !== e.last)
                    report($sformatf("frame_end %b, want %b", m_tlast, e.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // output side: random stalls plus a long hold when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 7);
            end
        end
    end

    stim_row_t stim_rows [] = '{
        '{OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{OP_PIXEL, 8'h01, 8'h80, 8'h7F, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{OP_PIXEL, 8'hAA, 8'h55, 8'hAA, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{OP_DRAIN, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h01, 8'h80, 8'h7F, 1'b1}},
        '{OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}}
    };

    initial
    begin
        bit       got;
        rgb_res_t res;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tuser = OP_PIXEL; s_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; items_sent = 0; results_seen = 0; frames_done = 0; cycles = 0;
        idle_on = 1'b0; hold_cycles = 0; stall_left = 0;
        kern_row[0] = '0; kern_row[1] = 48'd4096; kern_row[2] = '0;
        width_reg = 11'd640; height_reg = 16'd480;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        foreach (pix_store[i]) pix_store[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity kernel on a 3x1 frame: outputs equal inputs
        reg_write(REG_KMID, 48'h0000_1000_0000);
        reg_write(REG_WIDTH, 64'd3);
        reg_write(REG_HEIGHT, 64'd1);
        foreach (stim_rows[i])
        begin
            send_item(stim_rows[i].op,
                      {stim_rows[i].blue, stim_rows[i].green, stim_rows[i].red}, got, res);
            if (got !== stim_rows[i].has_res)
                report($sformatf("row %0d: result presence %b", i, got));
            else if (got && res !== stim_rows[i].res)
                report($sformatf("row %0d: predictor disagrees with table", i));
        end
        wait_drained();

        // zero width acts as one; zero height acts as one
        reg_write(REG_WIDTH, 64'd0);
        reg_write(REG_HEIGHT, 64'd0);
        run_frame(1'b0);
        wait_drained();

        idle_on = 1'b1;
        // oversized width clamps to the widest line; two rows, cut short past the wrap
        rand_kernel();
        reg_write(REG_WIDTH, 64'd2047);
        reg_write(REG_HEIGHT, 64'd2);
        for (int i = 0; i < LINE_MAX + 12; i++) push_item(OP_PIXEL, 24'($urandom));
        wait_drained();

        // tallest frame, cut short by a geometry write
        reg_write(REG_WIDTH, 64'd1);
        reg_write(REG_HEIGHT, 64'd65535);
        for (int i = 0; i < 30; i++) push_item(OP_PIXEL, 24'($urandom));
        wait_drained();

        // long output stall while input keeps coming
        reg_write(REG_WIDTH, 64'd4);
        reg_write(REG_HEIGHT, 64'd6);
        hold_cycles = 200;
        run_frame(1'b0);
        wait_drained();

        while (items_sent < 1250)
        begin
            if (items_sent > 1150) idle_on = 1'b0;
            if ($urandom_range(0, 1) == 0) rand_kernel();
            reg_write(REG_WIDTH, $urandom_range(1, 12));
            reg_write(REG_HEIGHT, $urandom_range(1, 6));
            for (int f = $urandom_range(1, 3); f > 0; f--)
            begin
                run_frame($urandom_range(0, 7) == 0);
                if (in_col != 0 || in_row != 0) break;
            end
            wait_drained();
        end

        $display("covered %0d items, %0d outputs checked, %0d whole frames",
                 items_sent, results_seen, frames_done);
        $display("geometry from 1x1 to the widest line, kernels incl. saturating coefs");
        if (errors == 0 && pending_q.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d outputs missing", errors, pending_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
